### hw/rtl/frr_pkg.sv
// Package for the fraction ratio reducer.
// Holds the operand and result transaction types shared by the RTL and its checker.
// No dependencies.
package frr_pkg;

  // Fixed width of every value field at the ports
  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic [DATA_W-1:0] larger_value;
    logic [DATA_W-1:0] smaller_value;
  } operand_t;

  typedef struct packed {
    logic [DATA_W-1:0] larger_reduced;
    logic [DATA_W-1:0] smaller_reduced;
    logic              both_zero_error;
  } result_t;

endpackage

### hw/rtl/fraction_ratio_reducer_top.sv
// Fraction ratio reducer: divides two unsigned terms by their greatest common divisor.
// Binary GCD followed by two restoring divisions on one shared subtractor.
// Depends on frr_pkg.
//
// Usage: pulse start with the operands while busy is low; the transaction is taken on that
// edge and busy stays high until the result appears for exactly one cycle with done high.
// The result cannot be stalled, so it must be captured in the done cycle. A new transaction
// may start in the done cycle. The compare/subtract and division work runs through a single
// (VALUE_WIDTH+2)-bit subtractor that serves the GCD compare/subtract steps and then one
// quotient bit per cycle of each division. With both terms nonzero the work runs as common
// factor-of-two removal, the binary GCD loop (one shift, swap or subtract per cycle), then
// two divisions of VALUE_WIDTH quotient bits each. A zero second term with a nonzero first
// one returns the first term with every factor of two removed and a zero second result.
// When either the first term or both terms are zero the result comes in the cycle after
// start and busy stays low. Both terms zero gives zero results with both_zero_error set.
// Operands are taken modulo 2^VALUE_WIDTH.
module fraction_ratio_reducer_top
  import frr_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  operand_t operands,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    TWOS,
    REDUCE,
    STRIP,
    DIV_A,
    DIV_B
  } state_t;

  state_t          state;
  logic [W-1:0]    u;        // GCD working term, then dividend/quotient
  logic [W-1:0]    v;        // GCD working term, ends as the odd divisor
  logic [W-1:0]    a_s;      // first term without common twos, then first quotient
  logic [W-1:0]    b_s;      // second term without common twos
  logic [W-1:0]    rem;      // division remainder
  logic [CW-1:0]   cnt;      // division bit counter

  logic [W-1:0]    a_in;
  logic [W-1:0]    b_in;
  logic [W:0]      sub_x;
  logic [W:0]      sub_y;
  logic [W+1:0]    diff;
  logic            borrow;
  logic [W:0]      rem_sh;
  logic [W-1:0]    quot_next;
  logic            last_bit;

  // Zero-extend a working value into a port field, or truncate it
  function automatic logic [DATA_W-1:0] to_field(input logic [W-1:0] x);
    logic [W+DATA_W-1:0] t;
    t = {{DATA_W{1'b0}}, x};
    return t[DATA_W-1:0];
  endfunction

  // Port operands reduced to the working width
  always_comb begin
    logic [W+DATA_W-1:0] ta;
    logic [W+DATA_W-1:0] tb;
    ta   = {{W{1'b0}}, operands.larger_value};
    tb   = {{W{1'b0}}, operands.smaller_value};
    a_in = ta[W-1:0];
    b_in = tb[W-1:0];
  end

  // Shared subtractor: GCD compare/subtract or one restoring division step
  assign rem_sh = {rem, u[W-1]};

  always_comb begin
    if (state == DIV_A || state == DIV_B) begin
      sub_x = rem_sh;
    end else begin
      sub_x = {1'b0, u};
    end
    sub_y = {1'b0, v};
  end

  assign diff      = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow    = diff[W+1];
  assign quot_next = {u[W-2:0], ~borrow};
  assign last_bit  = (cnt == CW'(W - 1));

  assign busy = (state != IDLE);

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            u   <= a_in;
            v   <= b_in;
            a_s <= a_in;
            b_s <= b_in;
            priority if (b_in == '0 && a_in == '0) begin
              result <= '{larger_reduced: '0, smaller_reduced: '0, both_zero_error: 1'b1};
              done   <= 1'b1;
            end else if (b_in == '0) begin
              state <= STRIP;
            end else if (a_in == '0) begin
              result <= '{larger_reduced: '0, smaller_reduced: to_field(W'(1)),
                          both_zero_error: 1'b0};
              done   <= 1'b1;
            end else begin
              state <= TWOS;
            end
          end
        end

        // Remove factors of two common to both terms
        TWOS: begin
          if (!u[0] && !v[0]) begin
            u   <= u >> 1;
            v   <= v >> 1;
            a_s <= a_s >> 1;
            b_s <= b_s >> 1;
          end else begin
            state <= REDUCE;
          end
        end

        // Binary GCD on odd part: one shift, swap or subtract per cycle
        REDUCE: begin
          priority if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (diff == '0) begin
            u     <= a_s;
            rem   <= '0;
            cnt   <= '0;
            state <= DIV_A;
          end else if (borrow) begin
            u <= v;
            v <= u;
          end else begin
            u <= diff[W-1:0];
          end
        end

        // Second term zero: drop every factor of two from the first
        STRIP: begin
          if (u[0]) begin
            result <= '{larger_reduced: to_field(u), smaller_reduced: '0,
                        both_zero_error: 1'b0};
            done   <= 1'b1;
            state  <= IDLE;
          end else begin
            u <= u >> 1;
          end
        end

        // Restoring division of the first term by the GCD odd part
        DIV_A: begin
          u   <= quot_next;
          rem <= borrow ? rem_sh[W-1:0] : diff[W-1:0];
          cnt <= cnt + 1'b1;
          if (last_bit) begin
            a_s   <= quot_next;
            u     <= b_s;
            rem   <= '0;
            cnt   <= '0;
            state <= DIV_B;
          end
        end

        // Restoring division of the second term
        DIV_B: begin
          u   <= quot_next;
          rem <= borrow ? rem_sh[W-1:0] : diff[W-1:0];
          cnt <= cnt + 1'b1;
          if (last_bit) begin
            result <= '{larger_reduced: to_field(a_s), smaller_reduced: to_field(quot_next),
                        both_zero_error: 1'b0};
            done   <= 1'b1;
            cnt    <= '0;
            state  <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/frr_checker.sv
// Port-level checker for the fraction ratio reducer, bound to the top level.
// Depends on frr_pkg and fraction_ratio_reducer_top.
module frr_checker
  import frr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input operand_t operands,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // An accepted transaction keeps the block busy next cycle unless it finished at once
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction did not occupy the block");

  // A result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done asserted while busy");

  // Error flag comes with zero results
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.both_zero_error) |->
      (result.larger_reduced == '0 && result.smaller_reduced == '0))
    else $error("error flag with nonzero results");

  // Each result is a single-cycle strobe tied to an earlier transaction
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

endmodule

bind fraction_ratio_reducer_top frr_checker u_frr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .operands (operands),
  .busy     (busy),
  .done     (done),
  .result   (result)
);

### test/tb_top.sv
// Self-checking testbench for fraction_ratio_reducer_top.
// Drives operand transactions, predicts each reduced ratio and checks every done strobe.
// Depends on frr_pkg and the fraction_ratio_reducer_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import frr_pkg::*;

  // Run limits, reckoned from the slowest item several times over
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned TAIL_CYCLES    = 400;
  localparam int unsigned RESET_CYCLES   = 11;

  // Kinds of random operand pairs
  typedef enum logic [2:0] {
    PAIR_FULL,
    PAIR_TINY,
    PAIR_COMMON,
    PAIR_POW2,
    PAIR_ZERO_SECOND,
    PAIR_ZERO_FIRST
  } pair_kind_t;

  logic     clk;
  logic     rst;
  logic     start;
  operand_t operands;
  logic     busy;
  logic     done;
  result_t  result;

  result_t     pending_ratios[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  fraction_ratio_reducer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Expected reduced ratio for one operand transaction
  function automatic result_t reduce_ratio(operand_t op);
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] r;
    result_t           res;
    res = '0;
    if (op.smaller_value != '0) begin
      // Euclid; divisor is nonzero since the second term is
      x = op.larger_value;
      y = op.smaller_value;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.larger_reduced  = op.larger_value / x;
      res.smaller_reduced = op.smaller_value / x;
    end else if (op.larger_value != '0) begin
      // zero second term: strip factors of two from the first
      x = op.larger_value;
      while (x[0] == 1'b0) x = x >> 1;
      res.larger_reduced = x;
    end else begin
      res.both_zero_error = 1'b1;
    end
    return res;
  endfunction

  // Send one transaction; returns at the accepting edge, start left high
  task automatic issue_ratio(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    operand_t op;
    op.larger_value  = a;
    op.smaller_value = b;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    operands <= op;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_ratios.push_back(reduce_ratio(op));
  endtask

  // Hold off the sender until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Result checker: every done strobe is matched against the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (pending_ratios.size() == 0) begin
        $error("unexpected result: larger_reduced %0h smaller_reduced %0h error %0b",
               result.larger_reduced, result.smaller_reduced, result.both_zero_error);
        error_count++;
      end else begin
        exp_res = pending_ratios.pop_front();
        if (result.larger_reduced !== exp_res.larger_reduced) begin
          $error("larger_reduced: expected %0h, actual %0h",
                 exp_res.larger_reduced, result.larger_reduced);
          error_count++;
        end
        if (result.smaller_reduced !== exp_res.smaller_reduced) begin
          $error("smaller_reduced: expected %0h, actual %0h",
                 exp_res.smaller_reduced, result.smaller_reduced);
          error_count++;
        end
        if (result.both_zero_error !== exp_res.both_zero_error) begin
          $error("both_zero_error: expected %0b, actual %0b",
                 exp_res.both_zero_error, result.both_zero_error);
          error_count++;
        end
      end
    end
  end

  // Extremes of both fields and ordinary GCD pairs in both orders
  task automatic test_directed_extremes();
    issue_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_ratio(32'hFFFF_FFFF, 32'd1);
    issue_ratio(32'd1, 32'hFFFF_FFFF);
    issue_ratio(32'd1, 32'd1);
    issue_ratio(32'd12, 32'd18);
    issue_ratio(32'd18, 32'd12);
    issue_ratio(32'h8000_0000, 32'h4000_0000);
    issue_ratio(32'h4000_0000, 32'h8000_0000);
    issue_ratio(32'h5555_5555, 32'hAAAA_AAAA);
    issue_ratio(32'hFFFF_FFFE, 32'd2);
    issue_ratio(32'hFFFF_FFFB, 32'hFFFF_FFF1);
    issue_ratio(32'd7, 32'd7);
  endtask

  // Zero first term, zero second term, and both zero
  task automatic test_zero_terms();
    issue_ratio(32'd0, 32'd0);
    issue_ratio(32'd0, 32'd1);
    issue_ratio(32'd0, 32'hFFFF_FFFF);
    issue_ratio(32'd0, 32'h8000_0000);
    issue_ratio(32'hFFFF_FFFF, 32'd0);
    issue_ratio(32'd1, 32'd0);
    issue_ratio(32'h8000_0000, 32'd0);
    issue_ratio(32'd12, 32'd0);
    issue_ratio(32'hAAAA_AAA0, 32'd0);
    issue_ratio(32'd0, 32'd0);
    issue_ratio(32'd0, 32'd0);
  endtask

  // Random pairs of mixed kinds at a given sender idle rate
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned count);
    pair_kind_t        kind;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] g;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      kind = pair_kind_t'($urandom_range(PAIR_ZERO_FIRST, PAIR_FULL));
      case (kind)
        PAIR_FULL: begin
          a = $urandom();
          b = $urandom();
        end
        PAIR_TINY: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        PAIR_COMMON: begin
          // shared divisor, products kept inside the field
          g = $urandom_range(1, 65535);
          a = g * $urandom_range(0, 32'hFFFF_FFFF / g);
          b = g * $urandom_range(1, 32'hFFFF_FFFF / g);
        end
        PAIR_POW2: begin
          a = $urandom() << $urandom_range(0, 31);
          b = $urandom() << $urandom_range(0, 31);
        end
        PAIR_ZERO_SECOND: begin
          a = ($urandom_range(0, 7) == 0) ? '0 : $urandom() << $urandom_range(0, 31);
          b = '0;
        end
        default: begin
          a = '0;
          b = $urandom();
        end
      endcase
      issue_ratio(a, b);
    end
  endtask

  // Stimulus sequence
  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    operands = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 13;
    test_directed_extremes();
    test_zero_terms();
    test_random_traffic(13, 500);
    drain_results();
    test_random_traffic(81, 500);
    test_random_traffic(0, 500);
    drain_results();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
